[hw/rtl/scts_pkg.sv]
// ----------------------------------------------------------------------------
// scts_pkg
// Shared types and constants of the sorted cohort table sieve.
// ----------------------------------------------------------------------------
`default_nettype none

package scts_pkg;

    localparam int TABLE_DEPTH_DEF  = 256;
    localparam int STATE_FIELDS_DEF = 3;
    localparam int IO_FIELDS        = 3;
    localparam int CFG_IDX_W        = 3;

    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SIEVE  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DROP  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ABS_NUMBER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ABS_FIRST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ABS_SECOND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ABS_THIRD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_FIRST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_SECOND = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_THIRD  = 3'd6;

    typedef struct packed {
        logic [1:0]         operation;
        logic [31:0]        number;
        logic signed [31:0] state_a;
        logic signed [31:0] state_b;
        logic signed [31:0] state_c;
        logic [7:0]         index;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [8:0]         count;
        logic [31:0]        out_number;
        logic signed [31:0] out_state_a;
        logic signed [31:0] out_state_b;
        logic signed [31:0] out_state_c;
    } t_out;

    typedef struct packed {
        logic        start;
        logic [31:0] val_a;
        logic [31:0] num_a;
        logic [31:0] val_b;
        logic [31:0] num_b;
    } t_mean_req;

    typedef struct packed {
        logic        done;
        logic [31:0] mean;
    } t_mean_rsp;

endpackage

`default_nettype wire

[hw/rtl/scts_ram.sv]
// ----------------------------------------------------------------------------
// scts_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/scts_mean.sv]
// ----------------------------------------------------------------------------
// scts_mean
// Size-weighted mean of two Q16.16 values: two products, then a 32-step
// restoring division of their sum by the summed sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module scts_mean (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire scts_pkg::t_mean_req  i_req,
    output scts_pkg::t_mean_rsp       o_rsp
);

    typedef enum logic [1:0] {M_IDLE, M_ADD, M_DIV} t_mstate;

    t_mstate     r_state;
    logic [63:0] r_p1;
    logic [31:0] r_ub;
    logic [31:0] r_nb;
    logic [32:0] r_dv;
    logic [32:0] r_rem;
    logic [31:0] r_lo;
    logic [31:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_done;
    logic [31:0] r_mean;

    logic [32:0] w_dv;
    logic [64:0] w_sum;
    logic [33:0] w_trial;
    logic        w_ge;
    logic [33:0] w_diff;
    logic [31:0] w_qn;

    assign w_dv    = {1'b0, i_req.num_a} + {1'b0, i_req.num_b};
    assign w_sum   = {1'b0, r_p1} + {1'b0, 64'(r_ub * r_nb)};
    assign w_trial = {r_rem, r_lo[31]};
    assign w_ge    = w_trial >= {1'b0, r_dv};
    assign w_diff  = w_trial - {1'b0, r_dv};
    assign w_qn    = {r_q[30:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_p1 <= 64'(i_req.val_a ^ scts_pkg::SIGN_BIT) * 64'(i_req.num_a);
                        r_ub <= i_req.val_b ^ scts_pkg::SIGN_BIT;
                        r_nb <= i_req.num_b;
                        r_dv <= w_dv;
                        if (w_dv == '0) begin
                            // both sizes zero: keep the base value
                            r_done <= 1'b1;
                            r_mean <= i_req.val_a;
                        end else begin
                            r_state <= M_ADD;
                        end
                    end
                end
                M_ADD: begin
                    // quotient fits 32 bits, so the top 33 bits start below the divisor
                    r_rem   <= w_sum[64:32];
                    r_lo    <= w_sum[31:0];
                    r_q     <= '0;
                    r_cnt   <= 5'd31;
                    r_state <= M_DIV;
                end
                M_DIV: begin
                    r_rem <= w_ge ? w_diff[32:0] : w_trial[32:0];
                    r_lo  <= {r_lo[30:0], 1'b0};
                    r_q   <= w_qn;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_mean  <= w_qn ^ scts_pkg::SIGN_BIT;
                        r_state <= M_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.mean = r_mean;

endmodule

`default_nettype wire

[hw/rtl/sorted_cohort_table_sieve_top.sv]
// ----------------------------------------------------------------------------
// sorted_cohort_table_sieve_top
// Sorted cohort table with insert, sieve (merge and compact) and read.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_stall | i_in   (scts_pkg::t_in)
//  out     | output    | o_out_valid/i_out_stall| o_out (scts_pkg::t_out)
//  cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One item at a time; the table memory has one write and one read port.
//  Read: the entry is read, captured, then registered out. Insert: entries are
//  read from the end and shifted up until the new one fits. Sieve: merges use
//  the similarity test and the bit-serial mean divider.
//  Reset clears the count; the table needs no clearing pass.
//  A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_cohort_table_sieve_top #(
    parameter int TABLE_DEPTH  = scts_pkg::TABLE_DEPTH_DEF,
    parameter int STATE_FIELDS = scts_pkg::STATE_FIELDS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire scts_pkg::t_in                     i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output scts_pkg::t_out                         o_out,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [scts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [31:0]                       i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int EW = 32 * (1 + STATE_FIELDS);
    localparam int KW = (STATE_FIELDS > 1) ? $clog2(STATE_FIELDS) : 1;
    localparam int XW = (CW > 8) ? CW : 8;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CHK, S_INS_LAST, S_RD_WAIT,
        S_SV_RD, S_SV_CHK, S_SV_SIM, S_SV_MEAN, S_SV_WAIT, S_SV_END, S_DONE
    } t_state;

    t_state      r_state;
    logic [CW-1:0] r_count;
    logic        r_ovalid;
    scts_pkg::t_out r_out;

    logic [31:0] r_tol_n;
    logic [31:0] r_abs [scts_pkg::IO_FIELDS];
    logic [15:0] r_rel [scts_pkg::IO_FIELDS];

    logic [31:0] r_new_n;
    logic [31:0] r_new_s [STATE_FIELDS];
    logic [AW-1:0] r_pos;

    logic [CW-1:0] r_j;
    logic [CW-1:0] r_w;
    logic        r_bvalid;
    logic [31:0] r_bn;
    logic [31:0] r_bs [STATE_FIELDS];
    logic [31:0] r_en;
    logic [31:0] r_es [STATE_FIELDS];
    logic [KW-1:0] r_k;

    logic [1:0]  r_status;
    logic        r_rdhit;

    // memory ports
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [EW-1:0] w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [EW-1:0] w_q;

    logic [EW-1:0] w_new_ent;
    logic [EW-1:0] w_base_ent;
    logic [EW-1:0] w_ent_ent;
    logic [31:0]   w_q_s [STATE_FIELDS];

    scts_pkg::t_mean_req w_mreq;
    scts_pkg::t_mean_rsp w_mrsp;

    logic w_accept;
    logic w_flush_wr;
    logic w_tol_zero;
    logic w_q_greater;
    logic w_sim;
    logic w_last_k;
    logic w_more;
    logic [XW-1:0] w_idx_x;
    logic [XW-1:0] w_cnt_x;
    logic [32:0]   w_nsum;

    assign w_new_ent[31:0]  = r_new_n;
    assign w_base_ent[31:0] = r_bn;
    assign w_ent_ent[31:0]  = r_en;
    for (genvar g = 0; g < STATE_FIELDS; g++) begin : g_pack
        assign w_new_ent[32*(g+1) +: 32]  = r_new_s[g];
        assign w_base_ent[32*(g+1) +: 32] = r_bs[g];
        assign w_ent_ent[32*(g+1) +: 32]  = r_es[g];
        assign w_q_s[g]                   = w_q[32*(g+1) +: 32];
    end

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_flush_wr = r_bn > r_tol_n;
    assign w_last_k   = 32'(r_k) == 32'(STATE_FIELDS - 1);
    assign w_more     = (r_j + CW'(1)) < r_count;
    assign w_idx_x    = XW'(i_in.index);
    assign w_cnt_x    = XW'(r_count);
    assign w_nsum     = {1'b0, r_bn} + {1'b0, r_en};

    always_comb begin
        w_tol_zero = 1'b1;
        for (int i = 0; i < scts_pkg::IO_FIELDS; i++) begin
            if (r_abs[i] != '0 || r_rel[i] != '0) begin
                w_tol_zero = 1'b0;
            end
        end
    end

    // stored entry strictly greater than the new one, lexicographic, signed
    always_comb begin
        logic decided;
        decided     = 1'b0;
        w_q_greater = 1'b0;
        for (int i = 0; i < STATE_FIELDS; i++) begin
            if (!decided && w_q_s[i] != r_new_s[i]) begin
                decided     = 1'b1;
                w_q_greater = $signed(w_q_s[i]) > $signed(r_new_s[i]);
            end
        end
    end

    // similarity of field r_k between base and current entry
    always_comb begin
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] d;
        logic signed [32:0] s;
        logic [32:0] mag;
        logic [48:0] lhs;
        logic [48:0] rhs;
        logic [31:0] atol;
        logic [15:0] rtol;
        ua   = r_bs[r_k] ^ scts_pkg::SIGN_BIT;
        ub   = r_es[r_k] ^ scts_pkg::SIGN_BIT;
        d    = (ua > ub) ? (ua - ub) : (ub - ua);
        s    = $signed({r_bs[r_k][31], r_bs[r_k]}) + $signed({r_es[r_k][31], r_es[r_k]});
        mag  = s[32] ? 33'(-s) : 33'(s);
        atol = '0;
        rtol = '0;
        if (32'(r_k) < 32'(scts_pkg::IO_FIELDS)) begin
            atol = r_abs[2'(r_k)];
            rtol = r_rel[2'(r_k)];
        end
        lhs  = {d, 17'b0};
        rhs  = 49'(rtol) * 49'(mag);
        w_sim = (d < atol) ||
                (rtol != '0 && (s[32] ? (lhs < rhs) : (lhs <= rhs)));
    end

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        w_wr_data = w_base_ent;
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        w_mreq.start = 1'b0;
        w_mreq.val_a = r_bs[r_k];
        w_mreq.num_a = r_bn;
        w_mreq.val_b = r_es[r_k];
        w_mreq.num_b = r_en;
        case (r_state)
            S_IDLE: begin
                w_rd_en   = 1'b1;
                w_rd_addr = AW'(w_idx_x);
            end
            S_INS_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_pos;
            end
            S_INS_CHK: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_pos + AW'(1);
                w_wr_data = w_q_greater ? w_new_ent : w_q;
            end
            S_INS_LAST: begin
                w_wr_en   = 1'b1;
                w_wr_addr = '0;
                w_wr_data = w_new_ent;
            end
            S_SV_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_j[AW-1:0];
            end
            S_SV_CHK: begin
                w_wr_en   = r_bvalid && (w_tol_zero || r_bn < r_tol_n) && w_flush_wr;
                w_wr_addr = r_w[AW-1:0];
            end
            S_SV_SIM: begin
                w_wr_en   = !w_sim && w_flush_wr;
                w_wr_addr = r_w[AW-1:0];
            end
            S_SV_MEAN: w_mreq.start = 1'b1;
            S_SV_END: begin
                w_wr_en   = w_flush_wr;
                w_wr_addr = r_w[AW-1:0];
            end
            default: ;
        endcase
    end

    scts_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_q)
    );

    scts_mean u_mean (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_mreq),
        .o_rsp  (w_mrsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_bvalid <= 1'b0;
            r_tol_n  <= '0;
            for (int i = 0; i < scts_pkg::IO_FIELDS; i++) begin
                r_abs[i] <= '0;
                r_rel[i] <= '0;
            end
        end else begin
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    scts_pkg::CFG_ABS_NUMBER: r_tol_n  <= i_cfg_data;
                    scts_pkg::CFG_ABS_FIRST:  r_abs[0] <= i_cfg_data;
                    scts_pkg::CFG_ABS_SECOND: r_abs[1] <= i_cfg_data;
                    scts_pkg::CFG_ABS_THIRD:  r_abs[2] <= i_cfg_data;
                    scts_pkg::CFG_REL_FIRST:  r_rel[0] <= i_cfg_data[15:0];
                    scts_pkg::CFG_REL_SECOND: r_rel[1] <= i_cfg_data[15:0];
                    scts_pkg::CFG_REL_THIRD:  r_rel[2] <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_new_n  <= i_in.number;
                        for (int i = 0; i < STATE_FIELDS; i++) begin
                            r_new_s[i] <= '0;
                        end
                        r_new_s[0] <= i_in.state_a;
                        if (STATE_FIELDS > 1) r_new_s[1 % STATE_FIELDS] <= i_in.state_b;
                        if (STATE_FIELDS > 2) r_new_s[2 % STATE_FIELDS] <= i_in.state_c;
                        r_status <= scts_pkg::ST_OK;
                        r_rdhit  <= 1'b0;
                        r_pos    <= AW'(r_count - CW'(1));
                        r_j      <= '0;
                        r_w      <= '0;
                        r_bvalid <= 1'b0;
                        r_state  <= S_DONE;
                        case (i_in.operation)
                            scts_pkg::OP_INSERT: begin
                                if (!(i_in.number > r_tol_n)) begin
                                    r_status <= scts_pkg::ST_DROP;
                                end else if (32'(r_count) >= 32'(TABLE_DEPTH)) begin
                                    r_status <= scts_pkg::ST_FULL;
                                end else if (r_count == '0) begin
                                    r_state <= S_INS_LAST;
                                end else begin
                                    r_state <= S_INS_RD;
                                end
                            end
                            scts_pkg::OP_SIEVE: begin
                                if (r_count != '0) r_state <= S_SV_RD;
                            end
                            scts_pkg::OP_READ: begin
                                if (w_idx_x < w_cnt_x) begin
                                    r_rdhit <= 1'b1;
                                    r_state <= S_RD_WAIT;
                                end else begin
                                    r_status <= scts_pkg::ST_RANGE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD_WAIT: begin
                    r_en <= w_q[31:0];
                    for (int i = 0; i < STATE_FIELDS; i++) r_es[i] <= w_q_s[i];
                    r_state <= S_DONE;
                end
                S_INS_RD: r_state <= S_INS_CHK;
                S_INS_CHK: begin
                    if (w_q_greater) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_DONE;
                    end else if (r_pos == '0) begin
                        r_state <= S_INS_LAST;
                    end else begin
                        r_pos   <= r_pos - AW'(1);
                        r_state <= S_INS_RD;
                    end
                end
                S_INS_LAST: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_DONE;
                end
                S_SV_RD: r_state <= S_SV_CHK;
                S_SV_CHK: begin
                    r_en <= w_q[31:0];
                    for (int i = 0; i < STATE_FIELDS; i++) r_es[i] <= w_q_s[i];
                    r_k <= '0;
                    if (!r_bvalid || w_tol_zero || r_bn < r_tol_n) begin
                        // start a new base with this entry
                        if (r_bvalid && w_flush_wr) r_w <= r_w + CW'(1);
                        r_bvalid <= 1'b1;
                        r_bn     <= w_q[31:0];
                        for (int i = 0; i < STATE_FIELDS; i++) r_bs[i] <= w_q_s[i];
                        r_j      <= r_j + CW'(1);
                        r_state  <= w_more ? S_SV_RD : S_SV_END;
                    end else begin
                        r_state <= S_SV_SIM;
                    end
                end
                S_SV_SIM: begin
                    if (!w_sim) begin
                        if (w_flush_wr) r_w <= r_w + CW'(1);
                        r_bn <= r_en;
                        for (int i = 0; i < STATE_FIELDS; i++) r_bs[i] <= r_es[i];
                        r_j     <= r_j + CW'(1);
                        r_state <= w_more ? S_SV_RD : S_SV_END;
                    end else if (w_last_k) begin
                        r_k     <= '0;
                        r_state <= S_SV_MEAN;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_SV_MEAN: r_state <= S_SV_WAIT;
                S_SV_WAIT: begin
                    if (w_mrsp.done) begin
                        r_bs[r_k] <= w_mrsp.mean;
                        if (w_last_k) begin
                            // absorb the entry: saturate the summed size
                            r_bn    <= w_nsum[32] ? 32'hFFFF_FFFF : w_nsum[31:0];
                            r_j     <= r_j + CW'(1);
                            r_state <= w_more ? S_SV_RD : S_SV_END;
                        end else begin
                            r_k     <= r_k + KW'(1);
                            r_state <= S_SV_MEAN;
                        end
                    end
                end
                S_SV_END: begin
                    r_count <= w_flush_wr ? (r_w + CW'(1)) : r_w;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid          <= 1'b1;
                        r_out.status      <= r_status;
                        r_out.count       <= 9'(r_count);
                        r_out.out_number  <= r_rdhit ? r_en : '0;
                        r_out.out_state_a <= r_rdhit ? r_es[0] : '0;
                        r_out.out_state_b <= (r_rdhit && STATE_FIELDS > 1)
                                             ? r_es[1 % STATE_FIELDS] : '0;
                        r_out.out_state_c <= (r_rdhit && STATE_FIELDS > 2)
                                             ? r_es[2 % STATE_FIELDS] : '0;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

[hw/rtl/scts_chk.sv]
// ----------------------------------------------------------------------------
// scts_chk
// Port-level checks of the sorted cohort table sieve.
// ----------------------------------------------------------------------------
`default_nettype none

module scts_chk #(
    parameter int TABLE_DEPTH = scts_pkg::TABLE_DEPTH_DEF
) (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            o_in_stall,
    input wire logic            o_out_valid,
    input wire logic            i_out_stall,
    input wire scts_pkg::t_out  o_out
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // one item at a time: the input closes after a transfer
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after a transfer");

    // full status only with a full table
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == scts_pkg::ST_FULL
        |-> 32'(o_out.count) == 32'(TABLE_DEPTH))
        else $error("full status with room left");

    // reported count never exceeds the table
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out.count) <= 32'(TABLE_DEPTH))
        else $error("count beyond table depth");

endmodule

bind sorted_cohort_table_sieve_top scts_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_scts_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out      (o_out)
);

`default_nettype wire

[tb/sorted_cohort_table_sieve_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_cohort_table_sieve_top_tb
// Drives insert, sieve and read items into the cohort table and compares
// every result against a cycle-free table model kept in the bench, over
// several tolerance settings, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_cohort_table_sieve_top_tb;
    import scts_pkg::*;

    localparam int DEPTH     = 256;
    localparam int MAX_CYCLE = 4_000_000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in        i_in;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out       o_out;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    sorted_cohort_table_sieve_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // table model
    logic [31:0] tol_size;
    logic [31:0] tol_abs [3];
    logic [15:0] tol_rel [3];
    int          tbl_count;
    logic [31:0] tbl_size [DEPTH];
    logic [31:0] tbl_val  [3][DEPTH];

    t_in  pending_items [$];
    t_out expected_results [$];
    int   n_errors;
    int   n_cycles;
    bit   quiet_phase;
    bit   hold_sender;
    int   long_hold;

    function automatic bit similar_field(logic [31:0] ra, logic [31:0] rb, int k);
        logic [63:0]        ua, ub, d, mag, lhs, rhs;
        logic signed [63:0] s;
        ua = {32'd0, ra ^ SIGN_BIT};
        ub = {32'd0, rb ^ SIGN_BIT};
        d = (ua > ub) ? ua - ub : ub - ua;
        s = $signed(ua) + $signed(ub) - 64'sd4294967296;
        mag = (s >= 0) ? s : -s;
        lhs = d << 17;
        rhs = {48'd0, tol_rel[k]} * mag;
        if (d < {32'd0, tol_abs[k]}) return 1;
        if (tol_rel[k] == 0) return 0;
        return (s >= 0) ? (lhs <= rhs) : (lhs < rhs);
    endfunction

    function automatic logic [31:0] size_weighted_mean(logic [31:0] ra, logic [31:0] na,
                                                       logic [31:0] rb, logic [31:0] nb);
        logic [95:0] tot;
        logic [95:0] q;
        logic [32:0] dv;
        dv = {1'b0, na} + {1'b0, nb};
        if (dv == 0) return ra;
        tot = {32'd0, ra ^ SIGN_BIT} * {64'd0, na} + {32'd0, rb ^ SIGN_BIT} * {64'd0, nb};
        q = tot / {63'd0, dv};
        return q[31:0] ^ SIGN_BIT;
    endfunction

    function automatic int order_vs(int pos, logic [31:0] v [3]);
        for (int k = 0; k < 3; k++) begin
            if (tbl_val[k][pos] != v[k])
                return ((tbl_val[k][pos] ^ SIGN_BIT) > (v[k] ^ SIGN_BIT)) ? 1 : -1;
        end
        return 0;
    endfunction

    task automatic sieve_table();
        bit          gone [DEPTH];
        bit          all_zero;
        bit          sim;
        int          base;
        int          w;
        logic [31:0] na, nb;
        logic [32:0] sum;
        base = 0;
        w = 0;
        all_zero = 1;
        for (int j = 0; j < DEPTH; j++) gone[j] = 0;
        for (int k = 0; k < 3; k++)
            if (tol_abs[k] != 0 || tol_rel[k] != 0) all_zero = 0;
        if (!all_zero) begin
            for (int j = 1; j < tbl_count; j++) begin
                if (tbl_size[base] < tol_size) begin
                    base = j;
                    continue;
                end
                sim = 1;
                for (int k = 0; k < 3; k++)
                    if (sim) sim = similar_field(tbl_val[k][base], tbl_val[k][j], k);
                if (!sim) begin
                    base = j;
                    continue;
                end
                na = tbl_size[base];
                nb = tbl_size[j];
                for (int k = 0; k < 3; k++)
                    tbl_val[k][base] = size_weighted_mean(tbl_val[k][base], na,
                                                          tbl_val[k][j], nb);
                sum = {1'b0, na} + {1'b0, nb};
                tbl_size[base] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                gone[j] = 1;
            end
        end
        for (int j = 0; j < tbl_count; j++) begin
            if (gone[j] || !(tbl_size[j] > tol_size)) continue;
            tbl_size[w] = tbl_size[j];
            for (int k = 0; k < 3; k++) tbl_val[k][w] = tbl_val[k][j];
            w++;
        end
        tbl_count = w;
    endtask

    task automatic predict_item(t_in it);
        t_out        r;
        logic [31:0] v [3];
        int          p;
        r = '0;
        r.status = ST_OK;
        v[0] = it.state_a;
        v[1] = it.state_b;
        v[2] = it.state_c;
        case (it.operation)
            OP_INSERT: begin
                if (!(it.number > tol_size)) r.status = ST_DROP;
                else if (tbl_count >= DEPTH) r.status = ST_FULL;
                else begin
                    p = tbl_count - 1;
                    while (p >= 0 && order_vs(p, v) <= 0) p--;
                    p++;
                    for (int j = tbl_count; j > p; j--) begin
                        tbl_size[j] = tbl_size[j-1];
                        for (int k = 0; k < 3; k++) tbl_val[k][j] = tbl_val[k][j-1];
                    end
                    tbl_size[p] = it.number;
                    for (int k = 0; k < 3; k++) tbl_val[k][p] = v[k];
                    tbl_count++;
                end
            end
            OP_SIEVE: sieve_table();
            OP_READ: begin
                if (it.index < tbl_count) begin
                    r.out_number  = tbl_size[it.index];
                    r.out_state_a = tbl_val[0][it.index];
                    r.out_state_b = tbl_val[1][it.index];
                    r.out_state_c = tbl_val[2][it.index];
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: ;
        endcase
        r.count = tbl_count[8:0];
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h (count %0d)", what, got, want, tbl_count);
        n_errors++;
    endtask

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > MAX_CYCLE) begin
            $display("timeout");
            $display("sorted_cohort_table_sieve_top_tb NOT OK");
            $finish;
        end
    end

    // driver: predict at the accepting edge, present at the falling edge
    int in_gap;
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_item(i_in);
            void'(pending_items.pop_front());
        end
    end
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_sender) begin
            i_in_valid <= 0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 0;
            end else if (pending_items.size() > 0 && !(i_in_valid && !o_in_stall
                         && pending_items.size() == 1)) begin
                if (!quiet_phase && $urandom_range(0, 15) == 0) begin
                    in_gap <= $urandom_range(1, 13) - 1;
                    i_in_valid <= 0;
                end else begin
                    // the head was taken at the last edge when valid was high
                    i_in_valid <= 1;
                    i_in <= (i_in_valid && !o_in_stall) ? pending_items[1] : pending_items[0];
                end
            end else begin
                i_in_valid <= 0;
            end
        end
    end

    // monitor
    int out_gap;
    t_out want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result status %0d", o_out.status);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_out.status != want.status) report_mismatch("status", o_out.status, want.status);
                if (o_out.count != want.count) report_mismatch("count", o_out.count, want.count);
                if (o_out.out_number != want.out_number)
                    report_mismatch("number", o_out.out_number, want.out_number);
                if (o_out.out_state_a != want.out_state_a)
                    report_mismatch("state_a", o_out.out_state_a, want.out_state_a);
                if (o_out.out_state_b != want.out_state_b)
                    report_mismatch("state_b", o_out.out_state_b, want.out_state_b);
                if (o_out.out_state_c != want.out_state_c)
                    report_mismatch("state_c", o_out.out_state_c, want.out_state_c);
            end
        end
    end
    always @(negedge i_clk) begin
        if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            i_out_stall <= 1;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_out_stall <= 1;
        end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
            out_gap <= $urandom_range(1, 13) - 1;
            i_out_stall <= 1;
        end else begin
            i_out_stall <= 0;
        end
    end

    function automatic logic [31:0] rand_state();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 3) << 16;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in make_item(logic [1:0] op, logic [31:0] num,
                                      logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                      logic [7:0] idx);
        t_in it;
        it.operation = op;
        it.number = num;
        it.state_a = a;
        it.state_b = b;
        it.state_c = c;
        it.index = idx;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_results.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (900) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ABS_NUMBER: tol_size = data;
            CFG_ABS_FIRST:  tol_abs[0] = data;
            CFG_ABS_SECOND: tol_abs[1] = data;
            CFG_ABS_THIRD:  tol_abs[2] = data;
            CFG_REL_FIRST:  tol_rel[0] = data[15:0];
            CFG_REL_SECOND: tol_rel[1] = data[15:0];
            CFG_REL_THIRD:  tol_rel[2] = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic set_tolerances(logic [31:0] sz, logic [31:0] ab, logic [15:0] rl);
        write_reg(CFG_ABS_NUMBER, sz);
        write_reg(CFG_ABS_FIRST, ab);
        write_reg(CFG_ABS_SECOND, ab ^ {$urandom_range(0, 1), 31'd0});
        write_reg(CFG_ABS_THIRD, ab);
        write_reg(CFG_REL_FIRST, {16'd0, rl});
        write_reg(CFG_REL_SECOND, {16'd0, rl});
        write_reg(CFG_REL_THIRD, {$urandom_range(0, 65535), rl});
    endtask

    // mostly clustered inserts so sieves merge, with reads and sieves mixed in
    task automatic queue_random(int n);
        logic [31:0] ca, cb, cc;
        int          r;
        ca = rand_state();
        cb = rand_state();
        cc = rand_state();
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) begin
                ca = rand_state();
                cb = rand_state();
                cc = rand_state();
            end
            if (r < 55)
                pending_items.push_back(make_item(OP_INSERT,
                    ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 32'h4_0000),
                    ca + $urandom_range(0, 3) * 32'h400, cb + $urandom_range(0, 1),
                    ($urandom_range(0, 3) == 0) ? rand_state() : cc, $urandom()));
            else if (r < 63)
                pending_items.push_back(make_item(OP_SIEVE, $urandom(), $urandom(),
                                                  $urandom(), $urandom(), $urandom()));
            else if (r < 98)
                pending_items.push_back(make_item(OP_READ, $urandom(), $urandom(), $urandom(),
                    $urandom(), ($urandom_range(0, 3) == 0) ? $urandom()
                                : $urandom_range(0, tbl_count + 2)));
            else
                pending_items.push_back(make_item(2'd3, $urandom(), $urandom(), $urandom(),
                                                  $urandom(), $urandom()));
        end
    endtask

    initial begin
        n_errors = 0;
        n_cycles = 0;
        quiet_phase = 0;
        hold_sender = 0;
        long_hold = 0;
        in_gap = 0;
        out_gap = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in = '0;
        i_out_stall = 0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        tol_size = 0;
        tbl_count = 0;
        for (int k = 0; k < 3; k++) begin
            tol_abs[k] = 0;
            tol_rel[k] = 0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, each operation, drop, out of range
        set_tolerances(32'h0000_8000, 32'h0001_0000, 16'h0800);
        pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, 8'd0));
        pending_items.push_back(make_item(OP_INSERT, 32'h0000_8000, 1, 2, 3, 0));
        pending_items.push_back(make_item(OP_INSERT, 32'hFFFF_FFFF, 32'h8000_0000,
                                          32'h8000_0000, 32'h8000_0000, 8'hFF));
        pending_items.push_back(make_item(OP_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        pending_items.push_back(make_item(OP_INSERT, 32'h0001_0000, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        pending_items.push_back(make_item(OP_INSERT, 32'h0000_9000, 32'h7FFF_F000,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        pending_items.push_back(make_item(OP_INSERT, 32'h0002_0000, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_INSERT, 32'h0002_0000, 32'hFFFF_0000, 0, 0, 0));
        for (int i = 0; i < 5; i++)
            pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, i[7:0]));
        pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, 8'd200));
        pending_items.push_back(make_item(2'd3, 32'hFFFF_FFFF, -1, -1, -1, 8'hFF));
        pending_items.push_back(make_item(OP_SIEVE, 0, 0, 0, 0, 0));
        for (int i = 0; i < 4; i++)
            pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, i[7:0]));
        wait_drained();

        // fill the table to the top while the receiver holds off
        set_tolerances(32'd0, 32'd0, 16'd0);
        long_hold = 400;
        for (int i = 0; i < 258; i++)
            pending_items.push_back(make_item(OP_INSERT, $urandom_range(1, 1000), rand_state(),
                                              $urandom(), $urandom(), 0));
        pending_items.push_back(make_item(OP_INSERT, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, 8'd255));
        pending_items.push_back(make_item(OP_SIEVE, 0, 0, 0, 0, 0));
        wait_drained();
        set_tolerances(32'd600, 32'd0, 16'd0);
        pending_items.push_back(make_item(OP_SIEVE, 0, 0, 0, 0, 0));
        wait_drained();

        // random phases across settings, each ending with a sieve of everything
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_tolerances(32'd0, 32'hFFFF_FFFF, 16'hFFFF);
                1: set_tolerances(32'h0000_4000, 32'h0000_1000, 16'h0100);
                2: set_tolerances(32'hFFFF_FFFF, 32'd0, 16'h0000);
                3: set_tolerances($urandom_range(0, 32'h2_0000), $urandom(), $urandom());
                4: set_tolerances(32'd0, 32'd0, 16'h0001);
                default: set_tolerances($urandom_range(0, 32'h1000), 32'h10_0000, 16'h4000);
            endcase
            if (ph == 5) quiet_phase = 1;
            queue_random(ph == 2 ? 50 : 240);
            pending_items.push_back(make_item(OP_SIEVE, 0, 0, 0, 0, 0));
            if (ph == 1) begin
                // sender pauses until everything has come back
                while (pending_items.size() > 0 || i_in_valid) @(posedge i_clk);
                hold_sender = 1;
                while (expected_results.size() > 0) @(posedge i_clk);
                hold_sender = 0;
            end
            wait_drained();
        end

        if (n_errors == 0) begin
            $display("sorted_cohort_table_sieve_top_tb OK");
        end else begin
            $display("sorted_cohort_table_sieve_top_tb NOT OK");
        end
        $finish;
    end
endmodule

`default_nettype wire
